// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Each macro samples on the rising edge of clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-looking concurrent assertion: the property must hold at every edge.
`define DCVE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication from a trigger condition to a consequence in the same cycle.
`define DCVE_ASSERT_IMP(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error(msg);

// Implication from a trigger condition to a consequence in the next cycle.
`define DCVE_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/dcve_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcve_pkg
// Types, codes and helpers shared by the draw command vertex expander.
// ----------------------------------------------------------------------------
package dcve_pkg;

  localparam int unsigned COORD_W         = 24;
  localparam int unsigned DEPTH_W         = 17;
  localparam int unsigned INDEX_W         = 16;
  localparam int unsigned COLOR_W         = 8;
  localparam int unsigned COORD_FRAC_BITS = 8;
  localparam int unsigned CNT_W           = 3;

  // One whole coordinate unit, used for the far corner of a point square.
  localparam logic signed [COORD_W-1:0] COORD_ONE = COORD_W'(1 << COORD_FRAC_BITS);
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Depth bias added to the frame command count.
  localparam int unsigned DEPTH_BIAS = 10;

  typedef enum logic [3:0] {
    FUNC_NONE      = 4'd0,
    FUNC_POINT     = 4'd1,
    FUNC_COLOR     = 4'd2,
    FUNC_CLEAR     = 4'd3,
    FUNC_RECT      = 4'd4,
    FUNC_CIRCLE    = 4'd5,
    FUNC_POLY      = 4'd6,
    FUNC_LINE      = 4'd7,
    FUNC_TRANSLATE = 4'd8,
    FUNC_TEXT      = 4'd9
  } func_e;

  typedef enum logic [1:0] {
    KIND_TRI   = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  // Expansion job handed from the front end to the vertex sequencer.
  typedef enum logic [2:0] {
    JOB_POINT   = 3'd0,
    JOB_FILL    = 3'd1,
    JOB_OUTLINE = 3'd2,
    JOB_LINE    = 3'd3,
    JOB_CLEAR   = 3'd4
  } job_op_e;

  typedef struct packed {
    job_op_e                   op;
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic [DEPTH_W-1:0]        depth;
    logic [COLOR_W-1:0]        red;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        blue;
  } job_t;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // Signed add clamped to the 24-bit coordinate range.
  function automatic logic signed [COORD_W-1:0] sat_add(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    if (s[COORD_W] != s[COORD_W-1]) begin
      return s[COORD_W] ? COORD_MIN : COORD_MAX;
    end
    return s[COORD_W-1:0];
  endfunction

  // Index of the final vertex of a job.
  function automatic logic [CNT_W-1:0] last_cnt(input job_op_e op);
    logic [CNT_W-1:0] n;
    unique case (op)
      JOB_POINT, JOB_FILL: n = CNT_W'(5);
      JOB_OUTLINE:         n = CNT_W'(7);
      JOB_LINE:            n = CNT_W'(1);
      default:             n = '0;
    endcase
    return n;
  endfunction

  // Corner select {x_sel, y_sel} for vertex cnt of a job: 0 picks the first
  // coordinate, 1 the second.
  function automatic logic [1:0] vtx_sel(input job_op_e op, input logic [CNT_W-1:0] cnt);
    logic [1:0] s;
    s = 2'b00;
    if (op == JOB_OUTLINE) begin
      case (cnt)
        3'd1, 3'd2: s = 2'b10;
        3'd3, 3'd4: s = 2'b11;
        3'd5, 3'd6: s = 2'b01;
        default:    s = 2'b00;
      endcase
    end else if (op == JOB_LINE) begin
      s = cnt[0] ? 2'b11 : 2'b00;
    end else if (op == JOB_POINT || op == JOB_FILL) begin
      case (cnt)
        3'd1:       s = 2'b10;
        3'd2, 3'd4: s = 2'b11;
        3'd5:       s = 2'b01;
        default:    s = 2'b00;
      endcase
    end
    return s;
  endfunction

  function automatic kind_e job_kind(input job_op_e op);
    kind_e k;
    unique case (op)
      JOB_POINT, JOB_FILL:  k = KIND_TRI;
      JOB_OUTLINE, JOB_LINE: k = KIND_LINE;
      default:              k = KIND_CLEAR;
    endcase
    return k;
  endfunction

endpackage

// File: rtl/core/dcve_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcve_front
// Accepts draw commands, keeps the drawing state and turns each emitting
// command into an expansion job.
// ----------------------------------------------------------------------------
module dcve_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dcve_pkg::INDEX_W-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [3:0]                      func_i,
  input  logic                            frame_start_i,
  input  logic signed [dcve_pkg::COORD_W-1:0] x1_i,
  input  logic signed [dcve_pkg::COORD_W-1:0] y1_i,
  input  logic signed [dcve_pkg::COORD_W-1:0] x2_i,
  input  logic signed [dcve_pkg::COORD_W-1:0] y2_i,
  input  logic                            fill_shape_i,
  input  logic [dcve_pkg::COLOR_W-1:0]    red_i,
  input  logic [dcve_pkg::COLOR_W-1:0]    green_i,
  input  logic [dcve_pkg::COLOR_W-1:0]    blue_i,
  input  logic                            fifo_full_i,
  output logic                            push_o,
  output dcve_pkg::job_t                  job_o
);
  import dcve_pkg::*;

  logic [INDEX_W-1:0]        frame_cmds_q;
  logic [INDEX_W-1:0]        idx_q, idx_d;
  logic [COLOR_W-1:0]        red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic signed [COORD_W-1:0] tx_q, tx_d, ty_q, ty_d;
  logic                      accept;
  logic [INDEX_W-1:0]        idx_eff;
  logic [COLOR_W-1:0]        red_eff, green_eff, blue_eff;
  logic signed [COORD_W-1:0] tx_eff, ty_eff;
  logic signed [INDEX_W+1:0] depth_raw;
  logic [DEPTH_W-1:0]        depth;
  func_e                     func;
  logic                      emit;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !fifo_full_i;
  assign accept      = in_valid_i && in_ready_o;
  assign func        = func_e'(func_i);

  // A frame start clears the state before the command itself is handled.
  assign idx_eff   = frame_start_i ? '0 : idx_q;
  assign red_eff   = frame_start_i ? '0 : red_q;
  assign green_eff = frame_start_i ? '0 : green_q;
  assign blue_eff  = frame_start_i ? '0 : blue_q;
  assign tx_eff    = frame_start_i ? '0 : tx_q;
  assign ty_eff    = frame_start_i ? '0 : ty_q;

  assign depth_raw = {2'b00, frame_cmds_q} + (INDEX_W+2)'(DEPTH_BIAS) - {2'b00, idx_eff};
  assign depth     = depth_raw[INDEX_W+1] ? '0 : depth_raw[DEPTH_W-1:0];

  always_comb begin
    idx_d   = idx_eff + INDEX_W'(1);
    red_d   = red_eff;
    green_d = green_eff;
    blue_d  = blue_eff;
    tx_d    = tx_eff;
    ty_d    = ty_eff;
    emit    = 1'b0;
    job_o.op    = JOB_CLEAR;
    job_o.x0    = sat_add(x1_i, tx_eff);
    job_o.y0    = sat_add(y1_i, ty_eff);
    job_o.x1    = sat_add(x2_i, tx_eff);
    job_o.y1    = sat_add(y2_i, ty_eff);
    job_o.depth = depth;
    job_o.red   = red_eff;
    job_o.green = green_eff;
    job_o.blue  = blue_eff;
    unique case (func)
      FUNC_POINT: begin
        emit     = 1'b1;
        job_o.op = JOB_POINT;
      end
      FUNC_COLOR: begin
        red_d   = red_i;
        green_d = green_i;
        blue_d  = blue_i;
      end
      FUNC_CLEAR: begin
        emit        = 1'b1;
        job_o.op    = JOB_CLEAR;
        job_o.x0    = '0;
        job_o.y0    = '0;
        job_o.depth = '0;
        job_o.red   = red_i;
        job_o.green = green_i;
        job_o.blue  = blue_i;
      end
      FUNC_RECT: begin
        emit     = 1'b1;
        job_o.op = fill_shape_i ? JOB_FILL : JOB_OUTLINE;
      end
      FUNC_LINE: begin
        emit     = 1'b1;
        job_o.op = JOB_LINE;
      end
      FUNC_TRANSLATE: begin
        tx_d = x1_i;
        ty_d = y1_i;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign push_o = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_cmds_q <= '0;
      idx_q        <= '0;
      red_q        <= '0;
      green_q      <= '0;
      blue_q       <= '0;
      tx_q         <= '0;
      ty_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        frame_cmds_q <= cfg_data_i;
      end
      if (accept) begin
        idx_q   <= idx_d;
        red_q   <= red_d;
        green_q <= green_d;
        blue_q  <= blue_d;
        tx_q    <= tx_d;
        ty_q    <= ty_d;
      end
    end
  end

endmodule

// File: rtl/core/dcve_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcve_fifo
// Short job queue between the command front end and the vertex sequencer.
// ----------------------------------------------------------------------------
module dcve_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dcve_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output dcve_pkg::job_t job_o
);
  import dcve_pkg::*;

  job_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   cnt_q;

  assign full_o  = cnt_q == (FIFO_AW+1)'(FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (FIFO_AW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (FIFO_AW+1)'(1);
      end
    end
  end

endmodule

// File: rtl/core/dcve_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcve_back
// Vertex sequencer: walks one job a vertex per cycle into the output register, unless the output stalls.
// ----------------------------------------------------------------------------
module dcve_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                empty_i,
  input  dcve_pkg::job_t                      job_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output dcve_pkg::kind_e                     kind_o,
  output logic signed [dcve_pkg::COORD_W-1:0] x_o,
  output logic signed [dcve_pkg::COORD_W-1:0] y_o,
  output logic [dcve_pkg::DEPTH_W-1:0]        depth_o,
  output logic [dcve_pkg::COLOR_W-1:0]        red_o,
  output logic [dcve_pkg::COLOR_W-1:0]        green_o,
  output logic [dcve_pkg::COLOR_W-1:0]        blue_o,
  output logic                                last_o
);
  import dcve_pkg::*;

  job_t             job_q, job_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             out_valid_q;
  logic             advance, is_last, load;
  logic [1:0]       sel;

  assign advance = busy_q && (!out_valid_q || out_ready_i);
  assign is_last = cnt_q == last_cnt(job_q.op);
  assign load    = !empty_i && (!busy_q || (advance && is_last));
  assign pop_o   = load;
  assign sel     = vtx_sel(job_q.op, cnt_q);

  // The far corner of a point square is derived here from the translated corner.
  always_comb begin
    job_d = job_i;
    if (job_i.op == JOB_POINT) begin
      job_d.x1 = sat_add(job_i.x0, COORD_ONE);
      job_d.y1 = sat_add(job_i.y0, COORD_ONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_d;
    end
    if (advance) begin
      kind_o  <= job_kind(job_q.op);
      x_o     <= sel[1] ? job_q.x1 : job_q.x0;
      y_o     <= sel[0] ? job_q.y1 : job_q.y0;
      depth_o <= job_q.depth;
      red_o   <= job_q.red;
      green_o <= job_q.green;
      blue_o  <= job_q.blue;
      last_o  <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (advance) begin
        if (is_last) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/draw_command_vertex_expander.sv
`timescale 1ns / 1ps
// A command's first result passes from the queue entry to the job register and then the output register.
// Throughput: one result per cycle while the output is not stalled; a command gives 1, 2, 6 or 8 results.
// Commands that give no result are accepted at the input and give nothing to the output.
// The output port at one vertex per cycle sets the rate; a two-job queue decouples the input.
// Reset (rst_ni low, asynchronous) clears the index, color, translation, frame command count,
// the queue and the output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
// draw_command_vertex_expander
// Expands 2D draw commands into triangle, line and clear-color vertices.
// ----------------------------------------------------------------------------
module draw_command_vertex_expander (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration: frame command count, sets the far depth.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [15:0]  cfg_data_i,
  // Command input.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: coord_x1, coord_y1, coord_x2, coord_y2, red_in, green_in, blue_in
  input  logic [119:0] s_axis_tdata,
  // tuser from bit 0: func (4), frame_start (1), fill_shape (1)
  input  logic [5:0]   s_axis_tuser,
  // Vertex output.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata from bit 0: vertex_x, vertex_y, depth_tenths, red_out, green_out, blue_out, zero pad
  output logic [95:0]  m_axis_tdata,
  // tuser from bit 0: vertex_kind (2)
  output logic [1:0]   m_axis_tuser,
  // tlast: last_of_run
  output logic         m_axis_tlast
);
  import dcve_pkg::*;

  logic                      push, pop, fifo_full, fifo_empty;
  job_t                      push_job, head_job;
  kind_e                     kind;
  logic signed [COORD_W-1:0] vx, vy;
  logic [DEPTH_W-1:0]        depth;
  logic [COLOR_W-1:0]        r_out, g_out, b_out;

  // Front end: owns the drawing state, classifies commands into jobs.
  dcve_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .func_i        (s_axis_tuser[3:0]),
    .frame_start_i (s_axis_tuser[4]),
    .x1_i          (s_axis_tdata[23:0]),
    .y1_i          (s_axis_tdata[47:24]),
    .x2_i          (s_axis_tdata[71:48]),
    .y2_i          (s_axis_tdata[95:72]),
    .fill_shape_i  (s_axis_tuser[5]),
    .red_i         (s_axis_tdata[103:96]),
    .green_i       (s_axis_tdata[111:104]),
    .blue_i        (s_axis_tdata[119:112]),
    .fifo_full_i   (fifo_full),
    .push_o        (push),
    .job_o         (push_job)
  );

  // The queue lets the front keep taking commands while a long job drains.
  dcve_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .empty_o (fifo_empty),
    .job_o   (head_job)
  );

  // Back end: one vertex per cycle, unless the output stalls, into a registered output stage.
  dcve_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (fifo_empty),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .kind_o      (kind),
    .x_o         (vx),
    .y_o         (vy),
    .depth_o     (depth),
    .red_o       (r_out),
    .green_o     (g_out),
    .blue_o      (b_out),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, b_out, g_out, r_out, depth, vy, vx};
  assign m_axis_tuser = kind;

endmodule

// File: rtl/core/dcve_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcve_checker
// Port-level checks for the draw command vertex expander, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcve_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [95:0]  m_axis_tdata,
  input logic [1:0]   m_axis_tuser,
  input logic         m_axis_tlast
);
  import dcve_pkg::*;

  logic out_stall;
  logic clear_out;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign clear_out = m_axis_tvalid && (m_axis_tuser == KIND_CLEAR);

  `DCVE_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid, "output item dropped while stalled")
  `DCVE_ASSERT_NEXT(a_out_stable, out_stall, $stable(m_axis_tdata), "stalled output changed")
  `DCVE_ASSERT_IMP(a_clear_last, clear_out, m_axis_tlast, "clear result not marked last")
  `DCVE_ASSERT_IMP(a_clear_zero, clear_out, m_axis_tdata[64:0] == '0, "clear result not zeroed")

endmodule

bind draw_command_vertex_expander dcve_checker u_dcve_checker (.*);

// File: bench/draw_command_vertex_expander_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// draw_command_vertex_expander_tb
// Self-checking bench for the draw command vertex expander. A driver offers
// commands from a queue and models the block's state on every accepted item.
// A monitor compares every vertex that leaves the block with the oldest
// expected vertex, field by field. In most phases both sides idle at random.
// The frame command count changes between phases, including its largest value.
// ----------------------------------------------------------------------------
module draw_command_vertex_expander_tb;
  import dcve_pkg::*;

  localparam int CLK_HALF_NS      = 10;
  localparam int RESET_CYCLES     = 12;
  localparam int MAX_IDLE         = 13;
  localparam int LONG_HOLD_CYCLES = 400;
  // Skipped commands give nothing to wait for.
  localparam int SETTLE_CYCLES    = 16;
  localparam int CYCLE_LIMIT      = 200_000;

  localparam longint COORD_HI = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_LO = -(longint'(1) << (COORD_W - 1));

  // Command codes that the block does not decode.
  localparam logic [3:0] FUNC_UNUSED_FIRST = 4'd10;
  localparam logic [3:0] FUNC_UNUSED_LAST  = 4'd15;

  // Corner order per vertex, two bits per vertex from vertex 0 up:
  // bit 1 picks the second x, bit 0 the second y.
  localparam logic [11:0] FILL_CORNERS    = {2'b01, 2'b11, 2'b00, 2'b11, 2'b10, 2'b00};
  localparam logic [15:0] OUTLINE_CORNERS = {2'b00, 2'b01, 2'b01, 2'b11,
                                             2'b11, 2'b10, 2'b10, 2'b00};

  typedef struct packed {
    logic [3:0]                func;
    logic                      frame_start;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
    logic                      fill;
    logic [COLOR_W-1:0]        red;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        blue;
    logic [3:0]                idle_before;
    logic                      drain_first;
  } command_t;

  typedef struct packed {
    kind_e                     kind;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [DEPTH_W-1:0]        depth;
    logic [COLOR_W-1:0]        red;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        blue;
    logic                      last;
  } vertex_t;

  // Block ports. Every input holds a known value from time zero.
  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         cfg_valid_i   = 1'b0;
  logic         cfg_ready_o;
  logic [15:0]  cfg_data_i    = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata  = '0;
  logic [5:0]   s_axis_tuser  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  // Model of the block's state, kept in step with accepted commands.
  logic [15:0]               frame_cmds;
  logic [INDEX_W-1:0]        cmd_index;
  logic [COLOR_W-1:0]        draw_red;
  logic [COLOR_W-1:0]        draw_green;
  logic [COLOR_W-1:0]        draw_blue;
  logic signed [COORD_W-1:0] shift_x;
  logic signed [COORD_W-1:0] shift_y;

  command_t pending_cmds[$];
  vertex_t  expected_vertices[$];
  command_t active_cmd;
  logic     offering      = 1'b0;
  int       idle_cycles   = 0;
  int       stall_left    = 0;
  int       hold_requests = 0;
  int       hold_served   = 0;
  int       mismatch_count = 0;
  int       cycle_count   = 0;
  bit       tx_gaps_on    = 1'b1;
  bit       rx_gaps_on    = 1'b1;

  draw_command_vertex_expander DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Vertex prediction
  // ---------------------------------------------------------------------------

  function automatic logic signed [COORD_W-1:0] clamp_sum(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    longint s;
    s = longint'(a) + longint'(b);
    if (s > COORD_HI) return COORD_MAX;
    if (s < COORD_LO) return COORD_MIN;
    return s[COORD_W-1:0];
  endfunction

  task automatic expect_vertex(
    input kind_e                     kind,
    input logic signed [COORD_W-1:0] x,
    input logic signed [COORD_W-1:0] y,
    input logic [DEPTH_W-1:0]        depth,
    input logic                      last
  );
    vertex_t v;
    v.kind  = kind;
    v.x     = x;
    v.y     = y;
    v.depth = depth;
    v.red   = draw_red;
    v.green = draw_green;
    v.blue  = draw_blue;
    v.last  = last;
    expected_vertices.insert(expected_vertices.size(), v);
  endtask

  // Updates the state model for one accepted command and queues the vertices
  // it must produce.
  task automatic expand_command(input command_t c);
    longint                    far_depth;
    logic [DEPTH_W-1:0]        depth;
    logic signed [COORD_W-1:0] ax, ay, bx, by;
    logic [1:0]                sel;
    vertex_t                   clr;
    if (c.frame_start) begin
      cmd_index  = '0;
      draw_red   = '0;
      draw_green = '0;
      draw_blue  = '0;
      shift_x    = '0;
      shift_y    = '0;
    end
    // Depth runs from the far plane toward the viewer and stops at zero.
    far_depth = longint'(DEPTH_BIAS) + longint'(frame_cmds) - longint'(cmd_index);
    if (far_depth < 0) far_depth = 0;
    depth = far_depth[DEPTH_W-1:0];
    ax = clamp_sum(c.x1, shift_x);
    ay = clamp_sum(c.y1, shift_y);
    bx = clamp_sum(c.x2, shift_x);
    by = clamp_sum(c.y2, shift_y);
    case (c.func)
      FUNC_POINT: begin
        // The unit square's far corner is added after the first saturation.
        bx = clamp_sum(ax, COORD_ONE);
        by = clamp_sum(ay, COORD_ONE);
        for (int i = 0; i < 6; i++) begin
          sel = FILL_CORNERS[2*i +: 2];
          expect_vertex(KIND_TRI, sel[1] ? bx : ax, sel[0] ? by : ay, depth, i == 5);
        end
      end
      FUNC_COLOR: begin
        draw_red   = c.red;
        draw_green = c.green;
        draw_blue  = c.blue;
      end
      FUNC_CLEAR: begin
        // The clear color travels in the vertex but does not become current.
        clr = '0;
        clr.kind  = KIND_CLEAR;
        clr.red   = c.red;
        clr.green = c.green;
        clr.blue  = c.blue;
        clr.last  = 1'b1;
        expected_vertices.insert(expected_vertices.size(), clr);
      end
      FUNC_RECT: begin
        if (c.fill) begin
          for (int i = 0; i < 6; i++) begin
            sel = FILL_CORNERS[2*i +: 2];
            expect_vertex(KIND_TRI, sel[1] ? bx : ax, sel[0] ? by : ay, depth, i == 5);
          end
        end else begin
          for (int i = 0; i < 8; i++) begin
            sel = OUTLINE_CORNERS[2*i +: 2];
            expect_vertex(KIND_LINE, sel[1] ? bx : ax, sel[0] ? by : ay, depth, i == 7);
          end
        end
      end
      FUNC_LINE: begin
        expect_vertex(KIND_LINE, ax, ay, depth, 1'b0);
        expect_vertex(KIND_LINE, bx, by, depth, 1'b1);
      end
      FUNC_TRANSLATE: begin
        shift_x = c.x1;
        shift_y = c.y1;
      end
      default: begin
      end
    endcase
    // Every command uses up an index, whether it draws or not.
    cmd_index = cmd_index + 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Command driver
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expand_command(active_cmd);
        offering = 1'b0;
      end
      if (!offering && pending_cmds.size() != 0) begin
        if (pending_cmds[0].drain_first && expected_vertices.size() != 0) begin
          idle_cycles = 0;
        end else if (idle_cycles < pending_cmds[0].idle_before) begin
          idle_cycles++;
        end else begin
          active_cmd  = pending_cmds.pop_front();
          offering    = 1'b1;
          idle_cycles = 0;
        end
      end
      s_axis_tvalid <= offering;
      s_axis_tdata  <= {active_cmd.blue, active_cmd.green, active_cmd.red,
                        active_cmd.y2, active_cmd.x2, active_cmd.y1, active_cmd.x1};
      s_axis_tuser  <= {active_cmd.fill, active_cmd.frame_start, active_cmd.func};
    end
  end

  // ---------------------------------------------------------------------------
  // Vertex monitor
  // ---------------------------------------------------------------------------

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_vertex();
    vertex_t got, want;
    got.kind  = kind_e'(m_axis_tuser);
    got.x     = m_axis_tdata[23:0];
    got.y     = m_axis_tdata[47:24];
    got.depth = m_axis_tdata[64:48];
    got.red   = m_axis_tdata[72:65];
    got.green = m_axis_tdata[80:73];
    got.blue  = m_axis_tdata[88:81];
    got.last  = m_axis_tlast;
    if (expected_vertices.size() == 0) begin
      $display("%0t: unexpected vertex, expected none, got kind %0d x %0d y %0d depth %0d",
               $time, got.kind, got.x, got.y, got.depth);
      mismatch_count++;
    end else begin
      want = expected_vertices.pop_front();
      compare_field("vertex_kind", want.kind, got.kind);
      compare_field("vertex_x", want.x, got.x);
      compare_field("vertex_y", want.y, got.y);
      compare_field("depth_tenths", want.depth, got.depth);
      compare_field("red_out", want.red, got.red);
      compare_field("green_out", want.green, got.green);
      compare_field("blue_out", want.blue, got.blue);
      compare_field("last_of_run", want.last, got.last);
    end
  endtask

  // With gaps on, the receiver draws a stall after each vertex; on request it
  // holds off for a long stretch so that the block backs up into its input.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_vertex();
        stall_left = rx_gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        stall_left  = LONG_HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: no finish within %0d cycles, %0d commands and %0d vertices outstanding",
               $time, CYCLE_LIMIT, pending_cmds.size(), expected_vertices.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2, 3, 4: return COORD_W'($urandom);
      default: return COORD_W'(int'($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  function automatic logic [3:0] random_skipped_func();
    case ($urandom_range(0, 9))
      0:       return FUNC_NONE;
      1:       return FUNC_CIRCLE;
      2:       return FUNC_POLY;
      3:       return FUNC_TEXT;
      default: return 4'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST));
    endcase
  endfunction

  function automatic bit is_skipped(input logic [3:0] func);
    case (func)
      FUNC_POINT, FUNC_COLOR, FUNC_CLEAR, FUNC_RECT, FUNC_LINE, FUNC_TRANSLATE: return 1'b0;
      default: return 1'b1;
    endcase
  endfunction

  function automatic command_t random_command();
    command_t    c;
    int unsigned pick;
    c = '0;
    c.frame_start = ($urandom_range(0, 15) == 0);
    c.x1    = rand_coord();
    c.y1    = rand_coord();
    c.x2    = rand_coord();
    c.y2    = rand_coord();
    c.fill  = 1'($urandom_range(0, 1));
    c.red   = COLOR_W'($urandom);
    c.green = COLOR_W'($urandom);
    c.blue  = COLOR_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 20)      c.func = FUNC_POINT;
    else if (pick < 45) c.func = FUNC_RECT;
    else if (pick < 60) c.func = FUNC_LINE;
    else if (pick < 70) c.func = FUNC_COLOR;
    else if (pick < 78) c.func = FUNC_TRANSLATE;
    else if (pick < 85) c.func = FUNC_CLEAR;
    else                c.func = random_skipped_func();
    return c;
  endfunction

  function automatic command_t build_cmd(
    input logic [3:0]                func,
    input logic                      frame_start,
    input logic signed [COORD_W-1:0] x1,
    input logic signed [COORD_W-1:0] y1,
    input logic signed [COORD_W-1:0] x2,
    input logic signed [COORD_W-1:0] y2,
    input logic                      fill,
    input logic [COLOR_W-1:0]        red,
    input logic [COLOR_W-1:0]        green,
    input logic [COLOR_W-1:0]        blue
  );
    command_t c;
    c = '0;
    c.func        = func;
    c.frame_start = frame_start;
    c.x1          = x1;
    c.y1          = y1;
    c.x2          = x2;
    c.y2          = y2;
    c.fill        = fill;
    c.red         = red;
    c.green       = green;
    c.blue        = blue;
    return c;
  endfunction

  task automatic queue_cmd(input command_t c);
    c.idle_before = tx_gaps_on ? 4'($urandom_range(0, MAX_IDLE)) : '0;
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic queue_skipped(input logic [3:0] func);
    command_t c;
    c = random_command();
    c.func = func;
    queue_cmd(c);
  endtask

  // Random phase; commands that the block ignores do not count.
  task automatic queue_random_commands(input int drawing_count);
    command_t c;
    int       n;
    n = 0;
    while (n < drawing_count) begin
      c = random_command();
      queue_cmd(c);
      if (!is_skipped(c.func)) n++;
    end
  endtask

  task automatic queue_directed();
    logic signed [COORD_W-1:0] one;
    one = COORD_ONE;
    queue_cmd(build_cmd(FUNC_COLOR, 1'b1, '0, '0, '0, '0, 1'b0, 8'hFF, 8'hFF, 8'hFF));
    queue_cmd(build_cmd(FUNC_POINT, 1'b0, '0, '0, '0, '0, 1'b0, '0, '0, '0));
    // Far corner of the unit square clamps at the top of the range.
    queue_cmd(build_cmd(FUNC_POINT, 1'b0, COORD_MAX, COORD_MAX, '0, '0, 1'b0, '0, '0, '0));
    queue_cmd(build_cmd(FUNC_POINT, 1'b0, COORD_MIN, COORD_MIN, '0, '0, 1'b0, '0, '0, '0));
    queue_cmd(build_cmd(FUNC_RECT, 1'b0, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1,
                        '0, '0, '0));
    queue_cmd(build_cmd(FUNC_RECT, 1'b0, -one, COORD_W'(2 * one), COORD_W'(3 * one),
                        COORD_W'(-4 * one), 1'b0, '0, '0, '0));
    queue_cmd(build_cmd(FUNC_LINE, 1'b0, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 1'b0,
                        '0, '0, '0));
    // The clear color must not become the drawing color.
    queue_cmd(build_cmd(FUNC_CLEAR, 1'b0, '0, '0, '0, '0, 1'b0, 8'h12, 8'h34, 8'h56));
    queue_cmd(build_cmd(FUNC_POINT, 1'b0, one, one, '0, '0, 1'b0, '0, '0, '0));
    // Translations at the extremes drive the sums into saturation both ways.
    queue_cmd(build_cmd(FUNC_TRANSLATE, 1'b0, COORD_MAX, COORD_MIN, '0, '0, 1'b0,
                        '0, '0, '0));
    queue_cmd(build_cmd(FUNC_POINT, 1'b0, COORD_MAX, COORD_MIN, '0, '0, 1'b0, '0, '0, '0));
    queue_cmd(build_cmd(FUNC_LINE, 1'b0, COORD_W'(-1), COORD_W'(1), COORD_MIN, COORD_MAX,
                        1'b0, '0, '0, '0));
    queue_cmd(build_cmd(FUNC_TRANSLATE, 1'b0, COORD_MIN, COORD_MAX, '0, '0, 1'b0,
                        '0, '0, '0));
    queue_cmd(build_cmd(FUNC_RECT, 1'b0, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 1'b0,
                        '0, '0, '0));
    queue_skipped(FUNC_NONE);
    queue_skipped(FUNC_CIRCLE);
    queue_skipped(FUNC_POLY);
    queue_skipped(FUNC_TEXT);
    queue_skipped(FUNC_UNUSED_FIRST);
    queue_skipped(FUNC_UNUSED_LAST);
    queue_cmd(build_cmd(FUNC_COLOR, 1'b0, '0, '0, '0, '0, 1'b0, 8'h00, 8'h00, 8'h00));
    queue_cmd(build_cmd(FUNC_RECT, 1'b0, one, -one, -one, one, 1'b1, '0, '0, '0));
    // A frame start drops the translation and color before the command runs.
    queue_cmd(build_cmd(FUNC_LINE, 1'b1, one, one, -one, -one, 1'b0, '0, '0, '0));
    queue_cmd(build_cmd(FUNC_TRANSLATE, 1'b1, one, -one, '0, '0, 1'b0, '0, '0, '0));
    queue_cmd(build_cmd(FUNC_CLEAR, 1'b0, '0, '0, '0, '0, 1'b0, 8'hFF, 8'h00, 8'hFF));
  endtask

  // Waits until every command has gone in and every vertex has come out, then
  // lets commands that draw nothing clear the block.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_cmds.size() != 0 || offering || expected_vertices.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_frame_commands(input logic [15:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    frame_cmds = value;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    command_t c;
    frame_cmds = '0;
    cmd_index  = '0;
    draw_red   = '0;
    draw_green = '0;
    draw_blue  = '0;
    shift_x    = '0;
    shift_y    = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_frame_commands(16'd30);
    @(negedge clk_i);
    queue_directed();
    wait_idle();

    // A zero frame count pushes the depth into its floor after ten commands of a frame.
    write_frame_commands('0);
    @(negedge clk_i);
    queue_random_commands(40);
    wait_idle();

    // The largest frame count gives the farthest depth.
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    write_frame_commands('1);
    @(negedge clk_i);
    queue_random_commands(15);
    wait_idle();

    // Back-to-back commands against a stalled output, then one command that
    // waits until the block has drained, then more commands with gaps.
    rx_gaps_on = 1'b1;
    write_frame_commands(16'($urandom));
    @(negedge clk_i);
    queue_random_commands(18);
    hold_requests++;
    tx_gaps_on = 1'b1;
    c = random_command();
    c.func = FUNC_LINE;
    queue_cmd(c);
    pending_cmds[$].drain_first = 1'b1;
    queue_random_commands(25);
    wait_idle();

    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    write_frame_commands(16'd7);
    @(negedge clk_i);
    queue_random_commands(20);
    wait_idle();

    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    write_frame_commands(16'($urandom));
    @(negedge clk_i);
    queue_random_commands(20);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/dcve_pkg.sv
rtl/core/dcve_front.sv
rtl/core/dcve_fifo.sv
rtl/core/dcve_back.sv
rtl/core/draw_command_vertex_expander.sv
rtl/core/dcve_checker.sv
bench/draw_command_vertex_expander_tb.sv
